// ----- rtl/core/four_frame_difference_motion_mask_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the four-frame difference motion mask
// Shared wrappers so every checker reports in the same form.
// ----------------------------------------------------------------------------
`ifndef FOUR_FRAME_DIFFERENCE_MOTION_MASK_MACROS_SVH
`define FOUR_FRAME_DIFFERENCE_MOTION_MASK_MACROS_SVH

// Checked only outside reset.
`define FFDM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ffdm assertion failed");

// Checked at every edge, reset included.
`define FFDM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("ffdm assertion failed");

`endif

// ----- rtl/core/ffdm_pkg.sv -----
// ----------------------------------------------------------------------------
// ffdm_pkg
// Types, constants and helpers shared by the motion mask modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffdm_pkg;

    localparam int MAX_PIXELS = 65536;
    localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LEN_W      = ADDR_W + 1;
    localparam int NUM_SLOTS  = 3;
    localparam int PIX_W      = 8;
    localparam int ROW_W      = NUM_SLOTS * PIX_W;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [PIX_W-1:0] MASK_ON  = 8'd255;
    localparam logic [PIX_W-1:0] MASK_OFF = 8'd0;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 4'd1;
    localparam int CFG_DATA_W = 17;

    typedef logic [1:0] slot_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ROW_W-1:0]  data;
    } ram_wr_t;

    typedef struct packed {
        logic              last;
        logic [PROD_W-1:0] product;
        logic [PIX_W-1:0]  mask;
    } result_t;

    function automatic slot_t slot_next(input slot_t s);
        slot_t r;
        r = (s == 2'd2) ? 2'd0 : s + 2'd1;
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] r;
        r = (a > b) ? (a - b) : (b - a);
        return r;
    endfunction

endpackage

// ----- rtl/core/ffdm_frame_ram.sv -----
// ----------------------------------------------------------------------------
// ffdm_frame_ram
// Frame store: one row per pixel position, three 8-bit frame slots per row.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffdm_frame_ram import ffdm_pkg::*; (
    input  logic              aclk,
    input  ram_wr_t           wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data
);

    logic [ROW_W-1:0] mem [0:MAX_PIXELS-1];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read returns the old row when the same address is written this cycle.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/ffdm_out_fifo.sv -----
// ----------------------------------------------------------------------------
// ffdm_out_fifo
// Small result queue between the pipeline and the master stream port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffdm_out_fifo import ffdm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  result_t               push_data,
    input  logic                  pop,
    output logic                  not_empty,
    output result_t               head,
    output logic [FIFO_CNT_W-1:0] count
);

    result_t                 entries [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg,  count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ----- rtl/core/four_frame_difference_motion_mask.sv -----
// ----------------------------------------------------------------------------
// four_frame_difference_motion_mask: one pixel per clock unless stalled.
// Result passes stage A, stage B and the result queue to the master port.
// Rate set by the row read/modify/write of the frame store, forwarded when
// consecutive pixels hit one position.
// After reset the store is swept to zero, one row a cycle, all 65536 rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_frame_difference_motion_mask import ffdm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel
    // mask output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [7:0] mask, [23:8] product
    output logic                  m_tlast    // last_in_frame
);

    logic [PROD_W-1:0]  threshold_reg;
    logic [16:0]        frame_pixels_reg;

    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    logic [ADDR_W-1:0]  pos_reg, pos_next;
    slot_t              oldest_reg, oldest_next;

    // stage A: row read back from the store
    logic               a_valid_reg;
    logic [PIX_W-1:0]   a_cur_reg;
    logic [ADDR_W-1:0]  a_addr_reg;
    slot_t              a_s3_reg;
    logic               a_last_reg;

    // stage B: differences, ahead of the multiply
    logic               b_valid_reg;
    logic [PIX_W-1:0]   b_d1_reg, b_d2_reg;
    logic               b_last_reg;

    // last row written, for back-to-back accesses to one position
    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic [ROW_W-1:0]   fwd_row_reg;

    logic               accept;
    logic [LEN_W-1:0]   frame_len;
    logic               last_in;
    logic [ROW_W-1:0]   ram_q;
    logic [ROW_W-1:0]   row_cur, row_new;
    slot_t              a_s2, a_s1;
    logic [PIX_W-1:0]   p1, p2, p3;
    ram_wr_t            ram_wr;
    logic [PROD_W-1:0]  product;
    result_t            result;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   in_flight;
    result_t            head;
    logic               fifo_not_empty;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= '0;
            frame_pixels_reg <= 17'd65536;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= cfg_data[15:0];
                REG_FRAME_PIXELS: frame_pixels_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // clearing sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(MAX_PIXELS - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // credit check: every pixel in flight has a queue entry waiting for it
    assign in_flight = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(a_valid_reg)
                     + (FIFO_CNT_W + 1)'(b_valid_reg);
    assign s_tready  = !clearing_reg && (in_flight < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign accept    = s_tvalid && s_tready;

    // frame length, zero taken as one, saturated to the store size
    always_comb begin
        if (frame_pixels_reg == '0) begin
            frame_len = LEN_W'(1);
        end else if (32'(frame_pixels_reg) > 32'(MAX_PIXELS)) begin
            frame_len = LEN_W'(MAX_PIXELS);
        end else begin
            frame_len = LEN_W'(frame_pixels_reg);
        end
    end

    assign last_in     = ((LEN_W'(pos_reg) + LEN_W'(1)) >= frame_len);
    assign pos_next    = last_in ? '0 : pos_reg + 1'b1;
    assign oldest_next = last_in ? slot_next(oldest_reg) : oldest_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            oldest_reg <= '0;
        end else if (accept) begin
            pos_reg    <= pos_next;
            oldest_reg <= oldest_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_cur_reg  <= s_tdata;
            a_addr_reg <= pos_reg;
            a_s3_reg   <= oldest_reg;
            a_last_reg <= last_in;
        end
    end

    ffdm_frame_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (ram_q)
    );

    // stage A: take the row, replace the oldest slot, write it back
    always_comb begin
        a_s2    = slot_next(a_s3_reg);
        a_s1    = slot_next(a_s2);
        row_cur = (fwd_valid_reg && fwd_addr_reg == a_addr_reg) ? fwd_row_reg : ram_q;
        p3      = row_cur[a_s3_reg * PIX_W +: PIX_W];
        p2      = row_cur[a_s2 * PIX_W +: PIX_W];
        p1      = row_cur[a_s1 * PIX_W +: PIX_W];
        row_new = row_cur;
        row_new[a_s3_reg * PIX_W +: PIX_W] = a_cur_reg;

        if (clearing_reg) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_addr_reg;
            ram_wr.data = '0;
        end else begin
            ram_wr.en   = a_valid_reg;
            ram_wr.addr = a_addr_reg;
            ram_wr.data = row_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
        end else begin
            b_valid_reg <= a_valid_reg;
            if (a_valid_reg) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg) begin
            fwd_addr_reg <= a_addr_reg;
            fwd_row_reg  <= row_new;
            b_d1_reg     <= abs_diff(p1, p3);
            b_d2_reg     <= abs_diff(a_cur_reg, p2);
            b_last_reg   <= a_last_reg;
        end
    end

    // stage B: multiply and threshold
    assign product        = PROD_W'(b_d1_reg) * PROD_W'(b_d2_reg);
    assign result.product = product;
    assign result.mask    = (product > threshold_reg) ? MASK_ON : MASK_OFF;
    assign result.last    = b_last_reg;

    ffdm_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (b_valid_reg),
        .push_data (result),
        .pop       (m_tvalid && m_tready),
        .not_empty (fifo_not_empty),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_tvalid = fifo_not_empty;
    assign m_tdata  = {head.product, head.mask};
    assign m_tlast  = head.last;

endmodule

// ----- rtl/core/ffdm_checker.sv -----
// ----------------------------------------------------------------------------
// ffdm_checker
// Port-level checks on the motion mask, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "four_frame_difference_motion_mask_macros.svh"

module ffdm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // no pixel taken at the start of the store sweep after reset
    `FFDM_ASSERT_ALWAYS(a_no_accept_after_reset, !aresetn |=> !s_tready)

    // mask is all ones or all zeros
    `FFDM_ASSERT(a_mask_code, m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'd255))

    // a zero product can never pass the threshold
    `FFDM_ASSERT(a_zero_prod_off, (m_tvalid && m_tdata[23:8] == 16'd0) |-> m_tdata[7:0] == 8'd0)

    // stalled result holds
    `FFDM_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind four_frame_difference_motion_mask ffdm_checker u_ffdm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/four_frame_difference_motion_mask_checker.sv -----
// ----------------------------------------------------------------------------
// Motion mask checker
// Watches the configuration, pixel and mask channels. Keeps its own three-frame
// store and predicts mask, product and frame end for every pixel accepted, then
// compares each mask transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_frame_difference_motion_mask_checker import ffdm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,   // [7:0] mask, [23:8] product
    input  logic                  m_tlast,   // last_in_frame
    output int                    errors,
    output int                    pending
);

    logic [PIX_W-1:0]      frame_mem [NUM_SLOTS][MAX_PIXELS];
    logic [PROD_W-1:0]     threshold_cfg;
    logic [CFG_DATA_W-1:0] frame_pixels_cfg;
    int                    position;
    int                    oldest;
    int                    result_count;
    result_t               pending_masks [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mask mismatch, result %0d: %s", $time, result_count, msg);
        errors++;
    endtask

    function automatic logic [PIX_W-1:0] pixel_delta(input logic [PIX_W-1:0] a,
                                                      input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // One pixel of frame n against frames n-1, n-2 and n-3 at the same position.
    function automatic void predict_motion(input logic [PIX_W-1:0] pix);
        int                len;
        int                s3;
        int                s2;
        int                s1;
        logic [PROD_W-1:0] prod;
        result_t           r;
        if (frame_pixels_cfg == 0)
            len = 1;
        else if (frame_pixels_cfg > MAX_PIXELS)
            len = MAX_PIXELS;
        else
            len = int'(frame_pixels_cfg);
        s3 = oldest;
        s2 = (oldest + 1) % NUM_SLOTS;
        s1 = (oldest + 2) % NUM_SLOTS;
        prod = PROD_W'(pixel_delta(frame_mem[s1][position], frame_mem[s3][position]))
             * PROD_W'(pixel_delta(pix, frame_mem[s2][position]));
        frame_mem[s3][position] = pix;
        r.mask    = (prod > threshold_cfg) ? MASK_ON : MASK_OFF;
        r.product = prod;
        r.last    = (position + 1 >= len);
        // a shrunk length also ends the frame here
        if (r.last) begin
            position = 0;
            oldest   = s2;
        end else begin
            position = position + 1;
        end
        pending_masks.push_back(r);
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            foreach (frame_mem[s, a])
                frame_mem[s][a] = '0;
            threshold_cfg    = '0;
            frame_pixels_cfg = CFG_DATA_W'(MAX_PIXELS);
            position         = 0;
            oldest           = 0;
            result_count     = 0;
            pending_masks.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_THRESHOLD)
                    threshold_cfg = cfg_data[PROD_W-1:0];
                else if (cfg_index == REG_FRAME_PIXELS)
                    frame_pixels_cfg = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_motion(s_tdata);
            if (m_tvalid && m_tready) begin
                if (pending_masks.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction, tdata %h tlast %b",
                                              m_tdata, m_tlast));
                end else begin
                    want = pending_masks.pop_front();
                    if (m_tdata[7:0] !== want.mask)
                        report_mismatch($sformatf("mask got %0d want %0d",
                                                  m_tdata[7:0], want.mask));
                    if (m_tdata[23:8] !== want.product)
                        report_mismatch($sformatf("product got %0d want %0d",
                                                  m_tdata[23:8], want.product));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("tlast got %b want %b",
                                                  m_tlast, want.last));
                end
                result_count++;
            end
        end
        pending = pending_masks.size();
    end

endmodule

// ----- tb/four_frame_difference_motion_mask_test.sv -----
// ----------------------------------------------------------------------------
// Motion mask testbench top
// Drives pixel frames and register writes into the motion mask block, with
// random gaps and back-pressure; the checker beside the block predicts and
// compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_frame_difference_motion_mask_test;
    import ffdm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 4'd7;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = 4'd15;
    localparam logic [CFG_DATA_W-1:0] PRODUCT_MAX   = 17'd65025;
    localparam int RANDOM_PIXELS = 530;
    localparam int HOLD_CYCLES   = 80;
    localparam int IDLE_PERCENT  = 6;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tlast;

    logic steady    = 1'b0;   // no gaps on either side
    logic hold_req  = 1'b0;   // ask the receiver for one long hold-off
    logic hold_done = 1'b0;   // receiver has served the hold-off
    int   errors;
    int   pending;

    four_frame_difference_motion_mask uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    four_frame_difference_motion_mask_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .errors    (errors),
        .pending   (pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Returns once the pixel transaction has happened; tvalid stays up.
    task automatic send_pixel(input logic [7:0] pix);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    // receiver
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin : stimulus
        logic [7:0]            step_seq [4] = '{8'd0, 8'd0, 8'd255, 8'd255};
        logic [7:0]            base;
        logic [7:0]            pix;
        logic [CFG_DATA_W-1:0] thr_val;
        logic [CFG_DATA_W-1:0] len_val;
        int                    sent;
        int                    ph;
        int                    count;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // one-pixel frames: every pixel rotates the store, full-scale step
        write_reg(REG_FRAME_PIXELS, '0);
        write_reg(REG_THRESHOLD, '0);
        foreach (step_seq[i])
            send_pixel(step_seq[i]);
        send_pixel(8'd0);
        drain();
        // maximum product sits exactly on the threshold: not moving
        write_reg(REG_THRESHOLD, 17'h1FE01);
        foreach (step_seq[i])
            send_pixel(step_seq[i]);
        drain();
        write_reg(REG_THRESHOLD, PRODUCT_MAX - 1);
        foreach (step_seq[i])
            send_pixel(step_seq[i]);
        drain();
        // oversized length saturates; unknown indexes are dropped
        write_reg(REG_FRAME_PIXELS, 17'h1FFFF);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        write_reg(REG_LAST_INDEX, '1);
        repeat (6) send_pixel(8'($urandom));
        drain();
        // shrink below the current position: next pixel closes the frame
        write_reg(REG_FRAME_PIXELS, 17'd3);
        repeat (4) send_pixel(8'($urandom));
        drain();

        sent = 0;
        ph   = 0;
        while (sent < RANDOM_PIXELS) begin
            case (ph)
                0: begin
                    thr_val = '0;
                    len_val = 17'd1;
                end
                1: begin
                    thr_val = PRODUCT_MAX;
                    len_val = CFG_DATA_W'(MAX_PIXELS);
                end
                2: begin
                    thr_val = 17'h0FFFF;
                    len_val = '0;
                end
                3: begin
                    thr_val = CFG_DATA_W'($urandom_range(0, 4000));
                    len_val = 17'd70000;
                end
                default: begin
                    thr_val = CFG_DATA_W'($urandom_range(0, 12000))
                            | (CFG_DATA_W'($urandom_range(1)) << 16);
                    len_val = CFG_DATA_W'($urandom_range(2, 24));
                end
            endcase
            write_reg(REG_THRESHOLD, thr_val);
            // sometimes keep the old length so the frame runs on across phases
            if (ph < 4 || $urandom_range(3) != 0)
                write_reg(REG_FRAME_PIXELS, len_val);
            steady = (ph == 5);
            if (ph == 6)
                hold_req = 1'b1;
            count = int'($urandom_range(30, 60));
            base  = 8'($urandom);
            repeat (count) begin
                case ($urandom_range(3))
                    0: pix = 8'($urandom);
                    1: pix = $urandom_range(1) ? 8'd255 : 8'd0;
                    default: pix = base + 8'($urandom_range(0, 15));
                endcase
                send_pixel(pix);
                sent++;
            end
            drain();
            steady = 1'b0;
            ph++;
        end

        repeat (10) @(negedge aclk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
